@@ hw/rtl/c2d_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// c2d_pkg: shared types and constants
// Item structs, op codes and sequencer states for the convolution block.
// ---------------------------------------------------------------------------
package c2d_pkg;

    localparam int unsigned ACC_W = 48;

    typedef enum logic [1:0] {
        OP_WR_MAP  = 2'd0,
        OP_WR_WGT  = 2'd1,
        OP_WR_BIAS = 2'd2,
        OP_COMPUTE = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        CFG_HEIGHT  = 3'd0,
        CFG_WIDTH   = 3'd1,
        CFG_CHANS   = 3'd2,
        CFG_FILTERS = 3'd3,
        CFG_KERNEL  = 3'd4,
        CFG_STEP    = 3'd5,
        CFG_PAD     = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] value;
        logic [4:0]         row;
        logic [4:0]         col;
        logic [3:0]         chan;
        logic [3:0]         filter;
        logic [2:0]         krow;
        logic [2:0]         kcol;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic               saturated;
        logic               bad_coordinate;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_WALK,
        ST_DRAIN,
        ST_BIAS,
        ST_OUT
    } t_state;

    // Control from sequencer to MAC unit
    typedef struct packed {
        logic clear;
        logic mac_en;
        logic bias_en;
    } t_mac_ctl;

endpackage
`default_nettype wire

@@ hw/rtl/conv2d_multichannel_bias.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// conv2d_multichannel_bias: direct 2-D convolution, NHWC, with bias
// Stores map, weights and biases; one compute item gives one output value.
//
// channel  direction  handshake       payload
// in       input      valid / stall   c2d_pkg::t_in_item
// out      output     valid / stall   c2d_pkg::t_out_item
// cfg      input      valid / ready   index, 32-bit data
//
// Write items are stored as they are accepted. A compute item walks its
// window one step per in-map window position and channel, one per padded
// position, set by the single shared MAC and the one read port of each store.
// Bad coordinates skip the walk and give a flagged result. Reset is synchronous
// and clears only control state; stores are undefined until written. The input
// is stalled while an item is in work or a result waits on the output.
// ---------------------------------------------------------------------------
module conv2d_multichannel_bias #(
    parameter int MAX_HEIGHT   = 32,
    parameter int MAX_WIDTH    = 32,
    parameter int MAX_CHANNELS = 16,
    parameter int MAX_FILTERS  = 16,
    parameter int MAX_KERNEL   = 5
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire c2d_pkg::t_in_item i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output c2d_pkg::t_out_item     o_out_data,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [2:0]        i_cfg_index,
    input  wire logic [31:0]       i_cfg_data
);
    import c2d_pkg::*;

    localparam int MAP_D = MAX_HEIGHT * MAX_WIDTH * MAX_CHANNELS;
    localparam int WGT_D = MAX_FILTERS * MAX_KERNEL * MAX_KERNEL * MAX_CHANNELS;
    localparam int MAP_AW = $clog2(MAP_D);
    localparam int WGT_AW = $clog2(WGT_D);
    localparam int FLT_AW = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1;
    localparam int BIAS_D = (MAX_FILTERS > 1) ? MAX_FILTERS : 2;

    // config registers
    logic [5:0] r_height, r_width;
    logic [4:0] r_chans, r_filters;
    logic [2:0] r_kernel, r_step, r_pad;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_height  <= 6'd32;
            r_width   <= 6'd32;
            r_chans   <= 5'd16;
            r_filters <= 5'd16;
            r_kernel  <= 3'd3;
            r_step    <= 3'd1;
            r_pad     <= 3'd0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_HEIGHT:  r_height  <= i_cfg_data[5:0];
                CFG_WIDTH:   r_width   <= i_cfg_data[5:0];
                CFG_CHANS:   r_chans   <= i_cfg_data[4:0];
                CFG_FILTERS: r_filters <= i_cfg_data[4:0];
                CFG_KERNEL:  r_kernel  <= i_cfg_data[2:0];
                CFG_STEP:    r_step    <= i_cfg_data[2:0];
                CFG_PAD:     r_pad     <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // effective (clamped) sizes
    logic [9:0] e_h, e_w, e_c, e_nf;
    logic [3:0] e_k, e_p;
    logic [2:0] e_s;
    always_comb begin
        e_h  = (r_height == 0) ? 10'd1 :
               (32'(r_height) > MAX_HEIGHT) ? 10'(MAX_HEIGHT) : 10'(r_height);
        e_w  = (r_width == 0) ? 10'd1 :
               (32'(r_width) > MAX_WIDTH) ? 10'(MAX_WIDTH) : 10'(r_width);
        e_c  = (r_chans == 0) ? 10'd1 :
               (32'(r_chans) > MAX_CHANNELS) ? 10'(MAX_CHANNELS) : 10'(r_chans);
        e_nf = (r_filters == 0) ? 10'd1 :
               (32'(r_filters) > MAX_FILTERS) ? 10'(MAX_FILTERS) : 10'(r_filters);
        e_k  = (r_kernel == 0) ? 4'd1 :
               (32'(r_kernel) > MAX_KERNEL) ? 4'(MAX_KERNEL) : 4'(r_kernel);
        e_s  = (r_step == 0) ? 3'd1 : (r_step > 3'd4) ? 3'd4 : r_step;
        e_p  = (4'(r_pad) > e_k - 4'd1) ? e_k - 4'd1 : 4'(r_pad);
    end

    // sequencer
    t_state   r_state, n_state;
    t_in_item r_item;
    logic [3:0] r_ky, r_kx;
    logic [9:0] r_ch;
    logic signed [11:0] r_y0, r_x0;
    logic [1:0] r_drain;
    logic r_bad;
    t_out_item r_out;
    logic r_out_valid;
    t_mac_ctl ctl;
    logic     last_step, pos_ok, rd_valid, r_rd_valid;
    logic signed [11:0] y, x;
    logic [MAP_AW-1:0] map_raddr;
    logic [WGT_AW-1:0] wgt_raddr;
    logic [15:0] map_rdata, wgt_rdata;
    logic [31:0] bias_rdata;
    logic signed [31:0] sat_value;
    logic sat_flag;
    logic accept;

    assign o_in_stall  = (r_state != ST_IDLE) || r_out_valid;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign y = r_y0 + 12'($signed({1'b0, r_ky}));
    assign x = r_x0 + 12'($signed({1'b0, r_kx}));
    assign pos_ok = (y >= 0) && (y < $signed({2'b0, e_h})) &&
                    (x >= 0) && (x < $signed({2'b0, e_w}));
    // a padded position ends its channel loop at once
    assign last_step = (r_ch == e_c - 10'd1 || !pos_ok) && (r_kx == e_k - 4'd1) &&
                       (r_ky == e_k - 4'd1);
    assign rd_valid = (r_state == ST_WALK) && pos_ok;

    // read addresses
    assign map_raddr = MAP_AW'(((32'(y[9:0]) * MAX_WIDTH + 32'(x[9:0])) *
                       MAX_CHANNELS) + 32'(r_ch));
    assign wgt_raddr = WGT_AW'((((32'(r_item.filter) * MAX_KERNEL + 32'(r_ky)) *
                       MAX_KERNEL + 32'(r_kx)) * MAX_CHANNELS) + 32'(r_ch));

    // output geometry check (out = (h+2p-k)/s+1)
    logic [10:0] span_h, span_w;
    logic [10:0] lim_h, lim_w;
    always_comb begin
        span_h = 11'(e_h) + 11'({e_p, 1'b0});
        span_w = 11'(e_w) + 11'({e_p, 1'b0});
        lim_h  = 11'(r_item.row) * 11'(e_s) + 11'(e_k);
        lim_w  = 11'(r_item.col) * 11'(e_s) + 11'(e_k);
    end

    // bad-coordinate flag from the captured item
    logic bad_now;
    assign bad_now = (lim_h > span_h) || (lim_w > span_w) ||
                     (10'(r_item.filter) >= e_nf);

    always_comb begin
        n_state = r_state;
        ctl     = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && t_op'(i_in_data.op) == OP_COMPUTE) begin
                    n_state = ST_SETUP;
                end
            end
            ST_SETUP: begin
                ctl.clear = 1'b1;
                n_state = bad_now ? ST_OUT : ST_WALK;
            end
            ST_WALK: begin
                if (last_step) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (r_drain == 2'd2) n_state = ST_BIAS;
            end
            ST_BIAS: begin
                ctl.bias_en = 1'b1;
                n_state = ST_OUT;
            end
            ST_OUT: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
        ctl.mac_en = r_rd_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_rd_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rd_valid <= rd_valid;
            if (r_state == ST_OUT) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_in_data;
        end
        priority case (r_state)
            ST_SETUP: begin
                r_bad <= bad_now;
                r_ky  <= '0;
                r_kx  <= '0;
                r_ch  <= '0;
                r_y0  <= $signed(12'(r_item.row) * 12'(e_s)) - 12'(e_p);
                r_x0  <= $signed(12'(r_item.col) * 12'(e_s)) - 12'(e_p);
            end
            ST_WALK: begin
                r_drain <= '0;
                if (r_ch == e_c - 10'd1 || !pos_ok) begin
                    r_ch <= '0;
                    if (r_kx == e_k - 4'd1) begin
                        r_kx <= '0;
                        r_ky <= r_ky + 4'd1;
                    end else begin
                        r_kx <= r_kx + 4'd1;
                    end
                end else begin
                    r_ch <= r_ch + 10'd1;
                end
            end
            ST_DRAIN: r_drain <= r_drain + 2'd1;
            ST_OUT: begin
                if (r_bad) begin
                    r_out <= '{result_value: '0, saturated: 1'b0, bad_coordinate: 1'b1};
                end else begin
                    r_out <= '{result_value: sat_value, saturated: sat_flag,
                               bad_coordinate: 1'b0};
                end
            end
            default: ;
        endcase
    end

    // store writes
    logic map_we, wgt_we, bias_we;
    logic [MAP_AW-1:0] map_waddr;
    logic [WGT_AW-1:0] wgt_waddr;
    always_comb begin
        map_we  = accept && t_op'(i_in_data.op) == OP_WR_MAP &&
                  32'(i_in_data.row) < MAX_HEIGHT && 32'(i_in_data.col) < MAX_WIDTH &&
                  32'(i_in_data.chan) < MAX_CHANNELS;
        wgt_we  = accept && t_op'(i_in_data.op) == OP_WR_WGT &&
                  32'(i_in_data.filter) < MAX_FILTERS &&
                  32'(i_in_data.krow) < MAX_KERNEL && 32'(i_in_data.kcol) < MAX_KERNEL &&
                  32'(i_in_data.chan) < MAX_CHANNELS;
        bias_we = accept && t_op'(i_in_data.op) == OP_WR_BIAS &&
                  32'(i_in_data.filter) < MAX_FILTERS;
        map_waddr = MAP_AW'(((32'(i_in_data.row) * MAX_WIDTH + 32'(i_in_data.col)) *
                    MAX_CHANNELS) + 32'(i_in_data.chan));
        wgt_waddr = WGT_AW'((((32'(i_in_data.filter) * MAX_KERNEL +
                    32'(i_in_data.krow)) * MAX_KERNEL + 32'(i_in_data.kcol)) *
                    MAX_CHANNELS) + 32'(i_in_data.chan));
    end

    c2d_ram #(.WIDTH(16), .DEPTH(MAP_D)) u_map (
        .i_clk(i_clk), .i_we(map_we), .i_waddr(map_waddr),
        .i_wdata(i_in_data.value[15:0]), .i_raddr(map_raddr), .o_rdata(map_rdata));

    c2d_ram #(.WIDTH(16), .DEPTH(WGT_D)) u_wgt (
        .i_clk(i_clk), .i_we(wgt_we), .i_waddr(wgt_waddr),
        .i_wdata(i_in_data.value[15:0]), .i_raddr(wgt_raddr), .o_rdata(wgt_rdata));

    c2d_ram #(.WIDTH(32), .DEPTH(BIAS_D)) u_bias (
        .i_clk(i_clk), .i_we(bias_we), .i_waddr(FLT_AW'(i_in_data.filter)),
        .i_wdata(i_in_data.value), .i_raddr(FLT_AW'(r_item.filter)),
        .o_rdata(bias_rdata));

    c2d_mac u_mac (
        .i_clk(i_clk), .i_ctl(ctl), .i_a(map_rdata), .i_b(wgt_rdata),
        .i_bias(bias_rdata), .o_sat_value(sat_value), .o_sat_flag(sat_flag));
endmodule
`default_nettype wire

@@ hw/rtl/c2d_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// c2d_ram: generic simple dual-port RAM
// One write and one read per cycle, registered read data.
// ---------------------------------------------------------------------------
module c2d_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ hw/rtl/c2d_mac.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// c2d_mac: shared multiply-accumulate unit
// Registered 16x16 product, then 48-bit accumulate, bias add and saturation.
// ---------------------------------------------------------------------------
module c2d_mac
    import c2d_pkg::*;
(
    input  wire logic               i_clk,
    input  wire t_mac_ctl           i_ctl,
    input  wire logic signed [15:0] i_a,
    input  wire logic signed [15:0] i_b,
    input  wire logic signed [31:0] i_bias,
    output logic signed [31:0]      o_sat_value,
    output logic                    o_sat_flag
);
    logic signed [31:0]      r_prod;
    logic                    r_prod_vld;
    logic signed [ACC_W-1:0] r_acc;

    // product stage
    always_ff @(posedge i_clk) begin
        r_prod     <= i_a * i_b;
        r_prod_vld <= i_ctl.mac_en;
    end

    // accumulate stage
    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_acc <= '0;
        end else if (i_ctl.bias_en) begin
            r_acc <= r_acc + ACC_W'(i_bias);
        end else if (r_prod_vld) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    // clip to 32 bits
    always_comb begin
        if (r_acc > ACC_W'(64'sh7FFF_FFFF)) begin
            o_sat_value = 32'sh7FFF_FFFF;
            o_sat_flag  = 1'b1;
        end else if (r_acc < -ACC_W'(64'sh8000_0000)) begin
            o_sat_value = 32'sh8000_0000;
            o_sat_flag  = 1'b1;
        end else begin
            o_sat_value = r_acc[31:0];
            o_sat_flag  = 1'b0;
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/c2d_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// c2d_checker: port-level checks for the convolution block
// Watches handshakes and result flags; bound to the top level.
// ---------------------------------------------------------------------------
module c2d_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_stall,
    input wire c2d_pkg::t_in_item  i_in_data,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire c2d_pkg::t_out_item o_out_data
);
    // a waiting result holds still
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // no input taken while a result waits
    a_in_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input open with result pending");

    // flagged coordinate means zero result
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.bad_coordinate |->
        o_out_data.result_value == 0 && !o_out_data.saturated)
        else $error("bad coordinate with nonzero result");

    // an accepted compute item blocks the next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_data.op == c2d_pkg::OP_COMPUTE
        |=> o_in_stall)
        else $error("input open right after a compute transfer");
endmodule

bind conv2d_multichannel_bias c2d_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
    .o_in_stall(o_in_stall), .i_in_data(i_in_data), .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall), .o_out_data(o_out_data));
`default_nettype wire
